// ----- design/oic_pkg.sv -----
// Shared types, constants and helpers for the onset interval classifier.
`timescale 1ns / 1ps

package oic_pkg;

  // Field and datapath widths
  localparam int TIME_W   = 48;
  localparam int TEMPO_W  = 20;
  localparam int VOTE_W   = 4;
  localparam int SUBDIV_W = 3;
  localparam int CLS_W    = 3;
  localparam int BEAT_W   = 36;                 // holds 60e9 / 1 mBPM
  localparam int CTR_W    = BEAT_W + 2;         // beat period times four
  localparam int PROD_W   = TIME_W + 7;         // interval times 100
  localparam int CMP_W    = (PROD_W > CTR_W + 7) ? PROD_W : CTR_W + 7;
  localparam int CNT_W    = $clog2(BEAT_W);
  localparam int LIM_SH   = 50;                 // intervals at or above 2^50 never match

  localparam logic [BEAT_W-1:0]  BEAT_NUM      = 36'd60000000000;
  localparam logic [TEMPO_W-1:0] TEMPO_DEFAULT = 20'd120000;
  localparam logic [VOTE_W-1:0]  VOTE_RESET    = 4'd3;
  localparam logic [VOTE_W-1:0]  VOTE_MAX      = 4'd15;
  localparam logic [6:0]         WIN_LO        = 7'd88;
  localparam logic [6:0]         WIN_MID       = 7'd100;
  localparam logic [6:0]         WIN_HI        = 7'd112;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMPO = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_VOTE  = 1'b1;

  // Request types
  localparam logic REQ_ONSET = 1'b0;
  localparam logic REQ_IDLE  = 1'b1;

  // Interval classes
  localparam logic [CLS_W-1:0] CLS_T       = 3'd0;
  localparam logic [CLS_W-1:0] CLS_HALF    = 3'd1;
  localparam logic [CLS_W-1:0] CLS_QUARTER = 3'd2;
  localparam logic [CLS_W-1:0] CLS_DOUBLE  = 3'd3;
  localparam logic [CLS_W-1:0] CLS_QUAD    = 3'd4;
  localparam logic [CLS_W-1:0] CLS_NONE    = 3'd7;

  typedef struct packed {
    logic              req_type;
    logic [TIME_W-1:0] onset_time_us;
  } oic_in_t;

  typedef struct packed {
    logic [TIME_W-1:0]   pulse_time_us;
    logic [SUBDIV_W-1:0] subdivision;
    logic [CLS_W-1:0]    class_code;
    logic                restart_history;
    logic                last_pulse;
  } oic_out_t;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DIV    = 5'b00010,
    ST_CLASS  = 5'b00100,
    ST_DECIDE = 5'b01000,
    ST_EMIT   = 5'b10000
  } oic_state_t;

  // Pulses per quarter for a class
  function automatic logic [SUBDIV_W-1:0] per_quarter(input logic [CLS_W-1:0] cls);
    logic [SUBDIV_W-1:0] pq;
    if (cls == CLS_HALF) begin
      pq = 3'd2;
    end else if (cls == CLS_QUARTER) begin
      pq = 3'd4;
    end else begin
      pq = 3'd1;
    end
    return pq;
  endfunction

endpackage

// ----- design/oic_beat_div.sv -----
// Iterative restoring divider: beat period = 60e9 / tempo (TEMPO_DEFAULT for a zero tempo), one quotient bit a cycle.
`timescale 1ns / 1ps

module oic_beat_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [oic_pkg::TEMPO_W-1:0]   tempo,
  output logic                          done,
  output logic [oic_pkg::BEAT_W-1:0]    beat
);
  import oic_pkg::*;

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [TEMPO_W-1:0] rem;
  logic [TEMPO_W-1:0] divisor;
  logic [TEMPO_W:0]   trial;
  logic [TEMPO_W:0]   diff;
  logic               ge;

  assign trial = {rem, BEAT_NUM[cnt]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        cnt     <= CNT_W'(BEAT_W - 1);
        rem     <= '0;
        divisor <= (tempo == '0) ? TEMPO_DEFAULT : tempo;
      end else if (busy) begin
        rem  <= ge ? diff[TEMPO_W-1:0] : trial[TEMPO_W-1:0];
        beat <= {beat[BEAT_W-2:0], ge};
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule

// ----- design/oic_window_cmp.sv -----
// Tolerance window compare: 88*c <= 100*x <= 112*c for one candidate centre.
`timescale 1ns / 1ps

module oic_window_cmp (
  input  logic [oic_pkg::PROD_W-1:0] dt100,
  input  logic                       dt_ok,
  input  logic [oic_pkg::CTR_W-1:0]  centre,
  output logic                       match
);
  import oic_pkg::*;

  logic [CMP_W-1:0] x_e;
  logic [CMP_W-1:0] lo;
  logic [CMP_W-1:0] hi;

  assign x_e = CMP_W'(dt100);
  assign lo  = CMP_W'(centre) * CMP_W'(WIN_LO);
  assign hi  = CMP_W'(centre) * CMP_W'(WIN_HI);

  assign match = dt_ok && (centre != '0) && (x_e >= lo) && (x_e <= hi);

endmodule

// ----- design/onset_interval_classifier_unit.sv -----
// Top level of the onset interval classifier: sequencer, vote state and beat output.
`timescale 1ns / 1ps

// Channel | Direction | Handshake            | Beat contents
// in      | in        | in_valid / in_stall   | req_type, onset_time_us
// out     | out       | out_valid / out_stall | pulse_time_us, subdivision, class_code,
//         |           |                       | restart_history, last_pulse
// cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Idle requests and first onsets are handled as they are accepted, and the sequencer
// stays idle. Any other onset holds the input while the sequencer runs its steps in
// order: the accept, a wait on the bit-serial beat-period divider, one step of the
// shared window comparator per class tried, a vote step and any pulse steps.
// Reset is synchronous; there is no clearing pass. A stalled output holds the
// pulse sequencer and so the input; once the last pulse of an onset sits in the
// output register the next input beat is taken.

module onset_interval_classifier_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  oic_pkg::oic_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output oic_pkg::oic_out_t                 out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [oic_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [oic_pkg::TEMPO_W-1:0]       cfg_data
);
  import oic_pkg::*;

  oic_state_t state;

  // configuration
  logic [TEMPO_W-1:0] tempo;
  logic [VOTE_W-1:0]  vote_run;

  // onset tracking
  logic [TIME_W-1:0]  prev_onset;
  logic               onset_seen;
  logic [TIME_W-1:0]  t_r;
  logic [TIME_W-1:0]  dt_r;
  logic               dt_ok;
  logic [PROD_W-1:0]  dt100;
  logic [TIME_W-1:0]  dt3q;

  // classification and vote
  logic [CLS_W-1:0]   cidx;
  logic [CLS_W-1:0]   cls_r;
  logic [CLS_W-1:0]   held_class;
  logic               class_held;
  logic [CLS_W-1:0]   vote_class;
  logic [VOTE_W-1:0]  vote_streak;

  // pulse emission
  logic [TIME_W-1:0]  prev_pulse;
  logic               pulse_seen;
  logic               first_r;
  logic [1:0]         k;

  logic               in_acc;
  logic               div_start;
  logic               div_done;
  logic [BEAT_W-1:0]  beat;
  logic [CTR_W-1:0]   centre;
  logic               match;

  logic [VOTE_W-1:0]  streak_inc;
  logic [VOTE_W-1:0]  streak_new;
  logic               dec_accept;
  logic               dec_applied;
  logic [VOTE_W-1:0]  dec_streak;

  logic [TIME_W-1:0]  off;
  logic [TIME_W-1:0]  cand;
  logic               emit_ok;
  logic               out_free;
  logic               load;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign div_start = in_acc && (in_data.req_type == REQ_ONSET) && onset_seen;

  oic_beat_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .tempo (tempo),
    .done  (div_done),
    .beat  (beat)
  );

  // centre under test for the current class step
  always_comb begin
    unique case (cidx)
      CLS_T:       centre = CTR_W'(beat);
      CLS_HALF:    centre = CTR_W'(beat >> 1);
      CLS_QUARTER: centre = CTR_W'(beat >> 2);
      CLS_DOUBLE:  centre = CTR_W'(beat) << 1;
      CLS_QUAD:    centre = CTR_W'(beat) << 2;
      default:     centre = '0;
    endcase
  end

  oic_window_cmp u_cmp (
    .dt100  (dt100),
    .dt_ok  (dt_ok),
    .centre (centre),
    .match  (match)
  );

  // vote: a held class re-arms the streak; a new class needs vote_run in a row
  assign streak_inc = (vote_streak == VOTE_MAX) ? VOTE_MAX : vote_streak + 1'b1;
  assign streak_new = (cls_r == vote_class) ? streak_inc : VOTE_W'(1);

  always_comb begin
    if (!class_held) begin
      dec_accept  = 1'b1;
      dec_applied = 1'b1;
      dec_streak  = VOTE_W'(1);
    end else if (cls_r == held_class) begin
      dec_accept  = 1'b1;
      dec_applied = 1'b0;
      dec_streak  = VOTE_W'(1);
    end else if (streak_new >= vote_run) begin
      dec_accept  = 1'b1;
      dec_applied = 1'b1;
      dec_streak  = VOTE_W'(1);
    end else begin
      dec_accept  = 1'b0;
      dec_applied = 1'b0;
      dec_streak  = streak_new;
    end
  end

  // pulse candidates: t-3dt/4, t-dt/2, t-dt/4, t; nondecreasing, t is the max
  always_comb begin
    unique case (k)
      2'd0:    off = dt3q;
      2'd1:    off = dt_r >> 1;
      2'd2:    off = dt_r >> 2;
      default: off = '0;
    endcase
  end

  assign cand     = t_r - off;
  assign emit_ok  = !pulse_seen || (cand > prev_pulse);
  assign out_free = !out_valid || !out_stall;
  assign load     = (state == ST_EMIT) && out_free && emit_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      tempo       <= '0;
      vote_run    <= VOTE_RESET;
      onset_seen  <= 1'b0;
      class_held  <= 1'b0;
      held_class  <= CLS_T;
      vote_class  <= CLS_NONE;
      vote_streak <= '0;
      pulse_seen  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_TEMPO: tempo    <= cfg_data;
          CFG_VOTE:  vote_run <= cfg_data[VOTE_W-1:0];
          default:   ;
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_data.req_type == REQ_IDLE) begin
              onset_seen  <= 1'b0;
              class_held  <= 1'b0;
              held_class  <= CLS_T;
              vote_class  <= CLS_NONE;
              vote_streak <= '0;
              pulse_seen  <= 1'b0;
            end else if (!onset_seen) begin
              prev_onset <= in_data.onset_time_us;
              onset_seen <= 1'b1;
            end else begin
              prev_onset <= in_data.onset_time_us;
              t_r        <= in_data.onset_time_us;
              dt_r       <= (in_data.onset_time_us > prev_onset)
                            ? in_data.onset_time_us - prev_onset : '0;
              state      <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          // interval products settle while the divider runs
          dt100 <= PROD_W'(dt_r) * PROD_W'(WIN_MID);
          dt3q  <= TIME_W'(((TIME_W + 2)'(dt_r) * (TIME_W + 2)'(3)) >> 2);
          dt_ok <= (dt_r != '0) && ((dt_r >> LIM_SH) == '0);
          if (div_done) begin
            cidx  <= CLS_T;
            state <= ST_CLASS;
          end
        end
        ST_CLASS: begin
          if (match) begin
            cls_r <= cidx;
            state <= ST_DECIDE;
          end else if (cidx == CLS_QUAD) begin
            // no class fits: drop the vote
            vote_streak <= '0;
            vote_class  <= CLS_NONE;
            state       <= ST_IDLE;
          end else begin
            cidx <= cidx + 1'b1;
          end
        end
        ST_DECIDE: begin
          vote_class  <= cls_r;
          vote_streak <= dec_streak;
          first_r     <= dec_applied;
          if (dec_applied) begin
            held_class <= cls_r;
            class_held <= 1'b1;
            pulse_seen <= 1'b0;
          end
          if (cls_r == CLS_QUAD) begin
            k <= 2'd0;
          end else if (cls_r == CLS_DOUBLE) begin
            k <= 2'd1;
          end else begin
            k <= 2'd3;
          end
          state <= dec_accept ? ST_EMIT : ST_IDLE;
        end
        ST_EMIT: begin
          if (out_free) begin
            if (emit_ok) begin
              prev_pulse <= cand;
              pulse_seen <= 1'b1;
              first_r    <= 1'b0;
            end
            if (k == 2'd3) begin
              state <= ST_IDLE;
            end else if (cls_r == CLS_QUAD) begin
              k <= k + 1'b1;
            end else begin
              k <= 2'd3;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.pulse_time_us   <= cand;
      out_data.subdivision     <= per_quarter(cls_r);
      out_data.class_code      <= cls_r;
      out_data.restart_history <= first_r;
      out_data.last_pulse      <= (cand == t_r);
    end
  end

  a_emit_held: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> class_held)
    else $error("pulse emission without a held class");

  a_div_to_class: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) && div_done |=> (state == ST_CLASS))
    else $error("divider finished but class search did not start");

  a_streak_vote: assert property (@(posedge clk) disable iff (rst)
    (vote_streak != '0) |-> (vote_class != CLS_NONE))
    else $error("vote streak running with no vote class");

  a_cidx_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLASS) |-> (cidx <= CLS_QUAD))
    else $error("class search index out of range");

endmodule
